// ===== hdl/trt_pkg.sv =====
// Shared types and constants of the tick rate timekeeper.
// Holds widths, derivation constants and the sequencer state type.
// No dependencies; compile first.
`default_nettype none

package trt_pkg;

    // Field widths
    localparam int HZ_W     = 24;
    localparam int RELOAD_W = 16;
    localparam int RATE_W   = 21;
    localparam int CNT_W    = 32;
    localparam int MS_W     = 32;
    localparam int FRAC_W   = 32;
    localparam int TS_W     = 64;

    // Internal widths: per-tick whole ms fits 6 bits (65535 * scale < 2^48),
    // the nanosecond sum fits 52 bits.
    localparam int PT_MS_W  = 6;
    localparam int NS_W     = 52;
    localparam int MUL_W    = 32;
    localparam int PROD_W   = 2 * MUL_W;

    // Divider widths
    localparam int DVD_W    = 22;
    localparam int DSR_W    = 24;
    localparam int STEP_W   = $clog2(DVD_W + 1);

    // Divide by three on the multiplier: floor(x / 3) = (x * THIRD_RECIP) >> 33
    // for any 32-bit x
    localparam logic [MUL_W-1:0]    THIRD_RECIP = 32'hAAAAAAAB;
    localparam int                  THIRD_SHIFT = 33;

    // Derivation constants
    localparam logic [DVD_W-1:0]    CLOCK_HZ   = 22'd3579545;
    localparam logic [HZ_W-1:0]     MIN_HZ     = 24'd18;
    localparam logic [HZ_W-1:0]     MAX_HZ     = 24'd1193181;
    localparam logic [RELOAD_W-1:0] RELOAD_MAX = 16'hFFFF;
    localparam logic [RELOAD_W-1:0] RELOAD_MIN = 16'd1;
    localparam logic [MUL_W-1:0]    MS_SCALE   = 32'hDBB3A062;
    localparam logic [MUL_W-1:0]    NS_PER_MS  = 32'd1000000;
    localparam logic [HZ_W-1:0]     RESET_HZ   = 24'd1000;

    // Sequencer states: derivation pass, idle, per-tick pass
    typedef enum logic [3:0] {
        ST_D_HZ_ISSUE,
        ST_D_HZ_WAIT,
        ST_D_HZ3_ISSUE,
        ST_D_HZ3_WAIT,
        ST_D_RL_ISSUE,
        ST_D_RL_WAIT,
        ST_D_RL3_ISSUE,
        ST_D_RL3_WAIT,
        ST_D_SCALE,
        ST_D_STORE,
        ST_IDLE,
        ST_T_MUL_MS,
        ST_T_MUL_FR,
        ST_T_SUM
    } trt_state_t;

endpackage

`default_nettype wire

// ===== hdl/trt_in_if.sv =====
// Input channel of the tick rate timekeeper: valid/ready plus tick flag.
// Depends on nothing.
`default_nettype none

interface trt_in_if;
    logic valid;
    logic ready;
    logic tick;

    modport source (output valid, output tick, input ready);
    modport sink   (input valid, input tick, output ready);
endinterface

`default_nettype wire

// ===== hdl/trt_out_if.sv =====
// Result channel of the tick rate timekeeper: valid/ready plus payload.
// Depends on trt_pkg for field widths.
`default_nettype none

interface trt_out_if;
    logic                              valid;
    logic                              ready;
    logic [trt_pkg::TS_W-1:0]          elapsed_ns;
    logic [trt_pkg::CNT_W-1:0]         tick_total;
    logic [trt_pkg::HZ_W-1:0]          rate_echo;
    logic [trt_pkg::RELOAD_W-1:0]      reload_used;
    logic [trt_pkg::RATE_W-1:0]        corrected_hz;

    modport source (output valid, output elapsed_ns, output tick_total,
                    output rate_echo, output reload_used, output corrected_hz,
                    input ready);
    modport sink   (input valid, input elapsed_ns, input tick_total,
                    input rate_echo, input reload_used, input corrected_hz,
                    output ready);
endinterface

`default_nettype wire

// ===== hdl/tick_rate_timekeeper_top.sv =====
// Top level of the tick rate timekeeper: sequencer, accumulators, output register.
// Depends on trt_pkg, trt_in_if, trt_out_if, trt_div and trt_mul.
//
//   Channel   Dir  Handshake      Payload
//   in_ch     in   valid/ready    tick (1)
//   out_ch    out  valid/ready    elapsed_ns (64), tick_total (32), rate_echo (24),
//                                 reload_used (16), corrected_hz (21)
//   cfg       in   cfg_we         cfg_wdata (24): requested_hz
//
// A tick item is accepted and accumulated, then passes twice through the
// shared 32x32 multiplier (whole ms, then fraction), then the nanosecond sum.
// An item with tick low is taken in the idle state and changes nothing.
// After reset and after every cfg write a derivation pass runs two divisions
// through the bit-serial divider and three multiplies (two divides by three,
// then the scale), during which in_ch.ready is low.
// A result waiting on out_ch holds the sequencer in its sum state; the next item
// is taken once it has moved on.
`default_nettype none

module tick_rate_timekeeper_top (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_we,
    input  wire logic [trt_pkg::HZ_W-1:0]  cfg_wdata,
    trt_in_if.sink                         in_ch,
    trt_out_if.source                      out_ch
);

    trt_pkg::trt_state_t state_reg, state_next;

    logic [trt_pkg::HZ_W-1:0]     hz_reg;
    logic [trt_pkg::CNT_W-1:0]    count_reg;
    logic [trt_pkg::MS_W-1:0]     ms_reg;
    logic [trt_pkg::FRAC_W-1:0]   frac_reg;
    logic [trt_pkg::RELOAD_W-1:0] reload_reg, reload_next;
    logic [trt_pkg::RATE_W-1:0]   rate_reg;
    logic [trt_pkg::PT_MS_W-1:0]  pt_ms_reg;
    logic [trt_pkg::FRAC_W-1:0]   pt_frac_reg;
    logic [trt_pkg::NS_W-1:0]     ns_reg;
    logic                         out_valid_reg;
    logic [trt_pkg::NS_W-1:0]     out_ns_reg;
    logic [trt_pkg::CNT_W-1:0]    out_count_reg;
    logic [trt_pkg::HZ_W-1:0]     out_hz_reg;
    logic [trt_pkg::RELOAD_W-1:0] out_reload_reg;
    logic [trt_pkg::RATE_W-1:0]   out_rate_reg;

    logic                         div_start;
    logic [trt_pkg::DVD_W-1:0]    div_dividend;
    logic [trt_pkg::DSR_W-1:0]    div_divisor;
    logic                         div_done;
    logic [trt_pkg::DVD_W-1:0]    div_quot;
    logic [trt_pkg::MUL_W-1:0]    mul_a;
    logic [trt_pkg::MUL_W-1:0]    mul_b;
    logic [trt_pkg::PROD_W-1:0]   mul_prod;
    logic                         in_ready;
    logic                         tick_go;
    logic                         out_load;
    logic [trt_pkg::FRAC_W:0]     frac_sum;
    logic [trt_pkg::RELOAD_W-1:0] reload_calc;

    trt_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quot_rnd (div_quot)
    );

    trt_mul u_mul (
        .clk  (clk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (mul_prod)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            trt_pkg::ST_D_HZ_ISSUE:  state_next = trt_pkg::ST_D_HZ_WAIT;
            trt_pkg::ST_D_HZ_WAIT:   if (div_done) state_next = trt_pkg::ST_D_HZ3_ISSUE;
            trt_pkg::ST_D_HZ3_ISSUE: state_next = trt_pkg::ST_D_HZ3_WAIT;
            trt_pkg::ST_D_HZ3_WAIT:  state_next = trt_pkg::ST_D_RL_ISSUE;
            trt_pkg::ST_D_RL_ISSUE:  state_next = trt_pkg::ST_D_RL_WAIT;
            trt_pkg::ST_D_RL_WAIT:   if (div_done) state_next = trt_pkg::ST_D_RL3_ISSUE;
            trt_pkg::ST_D_RL3_ISSUE: state_next = trt_pkg::ST_D_RL3_WAIT;
            trt_pkg::ST_D_RL3_WAIT:  state_next = trt_pkg::ST_D_SCALE;
            trt_pkg::ST_D_SCALE:     state_next = trt_pkg::ST_D_STORE;
            trt_pkg::ST_D_STORE:     state_next = trt_pkg::ST_IDLE;
            trt_pkg::ST_IDLE:        if (tick_go) state_next = trt_pkg::ST_T_MUL_MS;
            trt_pkg::ST_T_MUL_MS:    state_next = trt_pkg::ST_T_MUL_FR;
            trt_pkg::ST_T_MUL_FR:    state_next = trt_pkg::ST_T_SUM;
            trt_pkg::ST_T_SUM:       if (out_load) state_next = trt_pkg::ST_IDLE;
            default:                 state_next = trt_pkg::ST_D_HZ_ISSUE;
        endcase
        // A rate write restarts derivation
        if (cfg_we)
        begin
            state_next = trt_pkg::ST_D_HZ_ISSUE;
        end
    end

    // Sequencer outputs: handshakes, divider and multiplier operands
    always_comb
    begin
        in_ready     = (state_reg == trt_pkg::ST_IDLE);
        div_start    = 1'b0;
        div_dividend = trt_pkg::CLOCK_HZ;
        div_divisor  = hz_reg;
        mul_a        = frac_reg;
        mul_b        = trt_pkg::NS_PER_MS;
        case (state_reg)
            trt_pkg::ST_D_HZ_ISSUE:
            begin
                div_start = 1'b1;
            end
            trt_pkg::ST_D_HZ3_ISSUE, trt_pkg::ST_D_RL3_ISSUE:
            begin
                // Round half up of q / 3 is floor((q + 1) / 3)
                mul_a = trt_pkg::MUL_W'(div_quot) + trt_pkg::MUL_W'(1);
                mul_b = trt_pkg::THIRD_RECIP;
            end
            trt_pkg::ST_D_RL_ISSUE:
            begin
                div_start   = 1'b1;
                div_divisor = trt_pkg::DSR_W'(reload_reg);
            end
            trt_pkg::ST_D_SCALE:
            begin
                mul_a = trt_pkg::MUL_W'(reload_reg);
                mul_b = trt_pkg::MS_SCALE;
            end
            trt_pkg::ST_T_MUL_MS:
            begin
                mul_a = ms_reg;
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
        tick_go  = in_ch.valid && in_ready && in_ch.tick;
        out_load = (state_reg == trt_pkg::ST_T_SUM) && (!out_valid_reg || out_ch.ready);
    end

    // Clamp the reload to the valid range
    always_comb
    begin
        reload_calc = mul_prod[trt_pkg::THIRD_SHIFT +: trt_pkg::RELOAD_W];
        if (hz_reg <= trt_pkg::MIN_HZ)
        begin
            reload_next = trt_pkg::RELOAD_MAX;
        end
        else if (hz_reg >= trt_pkg::MAX_HZ)
        begin
            reload_next = trt_pkg::RELOAD_MIN;
        end
        else if (reload_calc == '0)
        begin
            reload_next = trt_pkg::RELOAD_MIN;
        end
        else
        begin
            reload_next = reload_calc;
        end
    end

    assign frac_sum = {1'b0, frac_reg} + {1'b0, pt_frac_reg};

    // Control state, rate register and accumulators
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= trt_pkg::ST_D_HZ_ISSUE;
            hz_reg        <= trt_pkg::RESET_HZ;
            count_reg     <= '0;
            ms_reg        <= '0;
            frac_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                hz_reg <= cfg_wdata;
            end
            // Accumulate the per-tick time on each accepted tick
            if (tick_go)
            begin
                frac_reg  <= frac_sum[trt_pkg::FRAC_W-1:0];
                ms_reg    <= ms_reg + trt_pkg::MS_W'(pt_ms_reg)
                             + trt_pkg::MS_W'(frac_sum[trt_pkg::FRAC_W]);
                count_reg <= count_reg + trt_pkg::CNT_W'(1);
            end
            // Drop the result once taken, hold it while stalled
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Derived values, nanosecond partial sum and result payload
    always_ff @(posedge clk)
    begin
        // Reload and achieved rate come from the divide-by-three product
        if (state_reg == trt_pkg::ST_D_HZ3_WAIT)
        begin
            reload_reg <= reload_next;
        end
        if (state_reg == trt_pkg::ST_D_RL3_WAIT)
        begin
            rate_reg <= mul_prod[trt_pkg::THIRD_SHIFT +: trt_pkg::RATE_W];
        end
        // Per-tick time is (reload * scale) >> 10 in 32.32
        if (state_reg == trt_pkg::ST_D_STORE)
        begin
            pt_ms_reg   <= mul_prod[trt_pkg::FRAC_W+10 +: trt_pkg::PT_MS_W];
            pt_frac_reg <= mul_prod[10 +: trt_pkg::FRAC_W];
        end
        if (state_reg == trt_pkg::ST_T_MUL_FR)
        begin
            ns_reg <= mul_prod[trt_pkg::NS_W-1:0];
        end
        if (out_load)
        begin
            out_ns_reg     <= ns_reg + trt_pkg::NS_W'(mul_prod[trt_pkg::PROD_W-1:trt_pkg::FRAC_W]);
            out_count_reg  <= count_reg;
            out_hz_reg     <= hz_reg;
            out_reload_reg <= reload_reg;
            out_rate_reg   <= rate_reg;
        end
    end

    assign in_ch.ready         = in_ready;
    assign out_ch.valid        = out_valid_reg;
    assign out_ch.elapsed_ns   = trt_pkg::TS_W'(out_ns_reg);
    assign out_ch.tick_total   = out_count_reg;
    assign out_ch.rate_echo    = out_hz_reg;
    assign out_ch.reload_used  = out_reload_reg;
    assign out_ch.corrected_hz = out_rate_reg;

`ifndef SYNTH
    a_tick_starts_pass: assert property (@(posedge clk) disable iff (!rst_n)
        (tick_go && !cfg_we) |=> (state_reg == trt_pkg::ST_T_MUL_MS))
        else $error("accepted tick did not start the multiply pass");

    a_count_steps_once: assert property (@(posedge clk) disable iff (!rst_n)
        tick_go |=> (count_reg == $past(count_reg) + trt_pkg::CNT_W'(1)))
        else $error("tick count did not advance by one");

    a_reload_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == trt_pkg::ST_IDLE) |-> (reload_reg != '0))
        else $error("derived reload is zero");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ch.ready) |=>
            (out_valid_reg && $stable(out_count_reg) && $stable(out_ns_reg)))
        else $error("stalled result overwritten");
`endif

endmodule

`default_nettype wire

// ===== hdl/trt_div.sv =====
// Iterative restoring divider, one quotient bit per cycle, with a
// round-half-up quotient output. Depends on trt_pkg.
`default_nettype none

module trt_div (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [trt_pkg::DVD_W-1:0]   dividend,
    input  wire logic [trt_pkg::DSR_W-1:0]   divisor,
    output logic                             done,
    output logic [trt_pkg::DVD_W-1:0]        quot_rnd
);

    logic [trt_pkg::DSR_W-1:0]  rem_reg, rem_next;
    logic [trt_pkg::DVD_W-1:0]  quo_reg, quo_next;
    logic [trt_pkg::DSR_W-1:0]  dsr_reg;
    logic [trt_pkg::STEP_W-1:0] step_reg, step_next;
    logic                       done_reg, done_next;
    logic [trt_pkg::DSR_W:0]    trial;
    logic                       round_up;

    // Trial subtract of the divisor from the shifted partial remainder
    assign trial = {rem_reg, quo_reg[trt_pkg::DVD_W-1]} - {1'b0, dsr_reg};

    // Advance one quotient bit a cycle
    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        step_next = step_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            step_next = trt_pkg::STEP_W'(trt_pkg::DVD_W);
        end
        else if (step_reg != '0)
        begin
            if (trial[trt_pkg::DSR_W])
            begin
                rem_next = {rem_reg[trt_pkg::DSR_W-2:0], quo_reg[trt_pkg::DVD_W-1]};
            end
            else
            begin
                rem_next = trial[trt_pkg::DSR_W-1:0];
            end
            quo_next  = {quo_reg[trt_pkg::DVD_W-2:0], ~trial[trt_pkg::DSR_W]};
            step_next = step_reg - trt_pkg::STEP_W'(1);
            done_next = (step_reg == trt_pkg::STEP_W'(1));
        end
    end

    // Hold step count and done flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            done_reg <= done_next;
        end
    end

    // Hold partial remainder, quotient and divisor
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start)
        begin
            dsr_reg <= divisor;
        end
    end

    // Round half up: bump the quotient when twice the remainder reaches the divisor
    assign round_up = ({rem_reg, 1'b0} >= {1'b0, dsr_reg});
    assign quot_rnd = quo_reg + trt_pkg::DVD_W'(round_up);
    assign done     = done_reg;

endmodule

`default_nettype wire

// ===== hdl/trt_mul.sv =====
// Shared 32x32 multiplier with a registered product.
// Depends on trt_pkg.
`default_nettype none

module trt_mul (
    input  wire logic                        clk,
    input  wire logic [trt_pkg::MUL_W-1:0]   op_a,
    input  wire logic [trt_pkg::MUL_W-1:0]   op_b,
    output logic [trt_pkg::PROD_W-1:0]       prod
);

    logic [trt_pkg::PROD_W-1:0] prod_reg;

    // Register the product every cycle
    always_ff @(posedge clk)
    begin
        prod_reg <= trt_pkg::PROD_W'(op_a) * trt_pkg::PROD_W'(op_b);
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

// ===== dv/trt_timebase_checker.sv =====
`timescale 1ns / 1ps
// Timebase checker for the tick rate timekeeper: predicts every tick result and compares it.
// Depends on trt_pkg, trt_in_if and trt_out_if; watches the block's channels only.

module trt_timebase_checker (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [trt_pkg::HZ_W-1:0] cfg_wdata,
    trt_in_if                        in_ch,
    trt_out_if                       out_ch,
    output int                       mismatches,
    output int                       outstanding,
    output int                       stamps_checked
);

    localparam longint unsigned OSC_HZ       = 64'd3579545;
    localparam longint unsigned DIVIDE_BY    = 64'd3;
    localparam longint unsigned SLOWEST_HZ   = 64'd18;
    localparam longint unsigned FASTEST_HZ   = 64'd1193181;
    localparam longint unsigned MS_PER_COUNT = 64'hDBB3A062;
    localparam longint unsigned NS_IN_MS     = 64'd1000000;
    localparam logic [trt_pkg::HZ_W-1:0] POWER_ON_HZ = 24'd1000;
    localparam int REPORT_LIMIT = 10;

    // Values derived from one rate setting
    typedef struct packed {
        logic [trt_pkg::RELOAD_W-1:0] reload;
        logic [trt_pkg::RATE_W-1:0]   achieved_hz;
        logic [trt_pkg::MS_W-1:0]     step_ms;
        logic [trt_pkg::FRAC_W-1:0]   step_frac;
    } timebase_t;

    // One expected result item
    typedef struct packed {
        logic [trt_pkg::TS_W-1:0]     elapsed_ns;
        logic [trt_pkg::CNT_W-1:0]    tick_total;
        logic [trt_pkg::HZ_W-1:0]     rate_echo;
        logic [trt_pkg::RELOAD_W-1:0] reload_used;
        logic [trt_pkg::RATE_W-1:0]   corrected_hz;
    } stamp_t;

    logic [trt_pkg::HZ_W-1:0]   rate_hz;
    timebase_t                  timebase;
    logic [trt_pkg::MS_W-1:0]   total_ms;
    logic [trt_pkg::FRAC_W-1:0] total_frac;
    logic [trt_pkg::CNT_W-1:0]  total_ticks;
    stamp_t                     pending_stamps[$];

    // Divide with the remainder rounded half up
    function automatic longint unsigned div_half_up(longint unsigned num, longint unsigned den);
        longint unsigned q;
        if (den == 0)
            return 0;
        q = num / den;
        if ((num % den) * 2 >= den)
            q = q + 1;
        return q;
    endfunction

    // Turn a requested rate into reload, achieved rate and time per tick
    function automatic timebase_t derive_timebase(logic [trt_pkg::HZ_W-1:0] hz);
        timebase_t       tb;
        longint unsigned quot;
        longint unsigned prod;
        if (hz <= SLOWEST_HZ)
            tb.reload = 16'hFFFF;
        else if (hz >= FASTEST_HZ)
            tb.reload = 16'd1;
        else
        begin
            quot = div_half_up(div_half_up(OSC_HZ, hz), DIVIDE_BY);
            tb.reload = quot[15:0];
            if (tb.reload == 0)
                tb.reload = 16'd1;
        end
        quot = div_half_up(div_half_up(OSC_HZ, tb.reload), DIVIDE_BY);
        tb.achieved_hz = quot[trt_pkg::RATE_W-1:0];
        prod = (longint'(tb.reload) * MS_PER_COUNT) >> 10;
        tb.step_ms   = prod[63:32];
        tb.step_frac = prod[31:0];
        return tb;
    endfunction

    // Watch configuration, accepted items and results
    always @(posedge clk or negedge rst_n)
    begin : watch
        stamp_t          want;
        stamp_t          got;
        longint unsigned frac_sum;
        if (!rst_n)
        begin
            rate_hz        = POWER_ON_HZ;
            timebase       = derive_timebase(POWER_ON_HZ);
            total_ms       = '0;
            total_frac     = '0;
            total_ticks    = '0;
            mismatches     = 0;
            stamps_checked = 0;
            pending_stamps.delete();
            outstanding   <= 0;
        end
        else
        begin
            // Compare a result item with the oldest expectation
            if (out_ch.valid && out_ch.ready)
            begin
                got = '{out_ch.elapsed_ns, out_ch.tick_total, out_ch.rate_echo,
                        out_ch.reload_used, out_ch.corrected_hz};
                if (pending_stamps.size() == 0)
                begin
                    mismatches = mismatches + 1;
                    if (mismatches <= REPORT_LIMIT)
                        $display("unexpected result: ns=%0d total=%0d rate=%0d reload=%0d hz=%0d",
                                 got.elapsed_ns, got.tick_total, got.rate_echo,
                                 got.reload_used, got.corrected_hz);
                end
                else
                begin
                    want = pending_stamps.pop_front();
                    stamps_checked = stamps_checked + 1;
                    if (got.elapsed_ns !== want.elapsed_ns || got.tick_total !== want.tick_total ||
                        got.rate_echo !== want.rate_echo || got.reload_used !== want.reload_used ||
                        got.corrected_hz !== want.corrected_hz)
                    begin
                        mismatches = mismatches + 1;
                        if (mismatches <= REPORT_LIMIT)
                        begin
                            $display("result %0d mismatch", stamps_checked);
                            $display("  expected ns=%0d total=%0d rate=%0d reload=%0d hz=%0d",
                                     want.elapsed_ns, want.tick_total, want.rate_echo,
                                     want.reload_used, want.corrected_hz);
                            $display("  actual   ns=%0d total=%0d rate=%0d reload=%0d hz=%0d",
                                     got.elapsed_ns, got.tick_total, got.rate_echo,
                                     got.reload_used, got.corrected_hz);
                        end
                    end
                end
            end

            // Advance the millisecond accumulator and the count on each tick, and queue the expected result
            if (in_ch.valid && in_ch.ready && in_ch.tick)
            begin
                frac_sum    = longint'(total_frac) + longint'(timebase.step_frac);
                total_frac  = frac_sum[31:0];
                total_ms    = total_ms + timebase.step_ms + {31'b0, frac_sum[32]};
                total_ticks = total_ticks + 1;
                want.elapsed_ns   = longint'(total_ms) * NS_IN_MS
                                  + ((longint'(total_frac) * NS_IN_MS) >> 32);
                want.tick_total   = total_ticks;
                want.rate_echo    = rate_hz;
                want.reload_used  = timebase.reload;
                want.corrected_hz = timebase.achieved_hz;
                pending_stamps.push_back(want);
            end

            // Derive the timebase again on a rate write
            if (cfg_we)
            begin
                rate_hz  = cfg_wdata;
                timebase = derive_timebase(cfg_wdata);
            end

            outstanding <= pending_stamps.size();
        end
    end

endmodule

// ===== dv/tick_rate_timekeeper_top_test.sv =====
`timescale 1ns / 1ps
// Stimulus and verdict for the tick rate timekeeper: rate writes, tick items, result stalls.
// Depends on trt_pkg, both channel interfaces, the block and trt_timebase_checker.

module tick_rate_timekeeper_top_test;

    localparam int ITEM_TARGET   = 1300;
    localparam int CALM_ITEMS    = 200;
    localparam int SETTLE_CYCLES = 200;
    localparam int CYCLE_LIMIT   = 400000;

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_we;
    logic [trt_pkg::HZ_W-1:0] cfg_wdata;
    bit                       idling_on;
    int                       mismatches;
    int                       outstanding;
    int                       stamps_checked;
    int                       cycle_count;
    int                       rates_written;
    int                       ticks_sent;
    int                       quiet_items;

    trt_in_if  in_ch ();
    trt_out_if out_ch ();

    tick_rate_timekeeper_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    trt_timebase_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .in_ch          (in_ch),
        .out_ch         (out_ch),
        .mismatches     (mismatches),
        .outstanding    (outstanding),
        .stamps_checked (stamps_checked)
    );

    // 20 ns clock
    initial
        clk = 1'b0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Stall the result channel in random bursts
    initial
    begin
        out_ch.ready <= 1'b0;
        forever
        begin
            if (idling_on && $urandom_range(0, 3) == 0)
            begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge clk);
        end
    end

    // Give up after a generous number of cycles
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count = cycle_count + 1;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    // Offer one item, after an optional idle burst, and hold it until taken
    task automatic offer_item(input logic tick_bit);
        if (idling_on && $urandom_range(0, 3) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.tick  <= tick_bit;
        do
            @(posedge clk);
        while (!in_ch.ready);
        if (tick_bit)
            ticks_sent = ticks_sent + 1;
        else
            quiet_items = quiet_items + 1;
    endtask

    // Wait for every result, let the block settle, then write a new rate
    task automatic write_rate(input logic [trt_pkg::HZ_W-1:0] hz);
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= hz;
        @(posedge clk);
        cfg_we <= 1'b0;
        rates_written = rates_written + 1;
    endtask

    initial
    begin
        logic [trt_pkg::HZ_W-1:0] hz;
        int                       burst;
        logic                     tick_bit;

        rst_n         = 1'b0;
        idling_on     = 1'b1;
        rates_written = 0;
        ticks_sent    = 0;
        quiet_items   = 0;
        in_ch.valid  <= 1'b0;
        in_ch.tick   <= 1'b0;
        cfg_we       <= 1'b0;
        cfg_wdata    <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Power-on rate, with an item that carries no tick
        offer_item(1'b1);
        offer_item(1'b1);
        offer_item(1'b0);
        offer_item(1'b1);

        // Rates at and around both clamps, the widest value, then back to the default
        write_rate(24'd0);
        offer_item(1'b1);
        offer_item(1'b1);
        write_rate(24'd18);
        offer_item(1'b1);
        write_rate(24'd19);
        offer_item(1'b1);
        offer_item(1'b0);
        write_rate(24'd1193180);
        offer_item(1'b1);
        write_rate(24'd1193181);
        offer_item(1'b1);
        write_rate(24'hFFFFFF);
        offer_item(1'b1);
        offer_item(1'b1);
        write_rate(24'd1000);
        offer_item(1'b1);

        // Random rates, each followed by a run of items; calm at the end
        while (ticks_sent + quiet_items < ITEM_TARGET)
        begin
            case ($urandom_range(0, 3))
                0:       hz = trt_pkg::HZ_W'($urandom_range(0, 24'hFFFFFF));
                1:       hz = trt_pkg::HZ_W'($urandom_range(0, 40));
                2:       hz = trt_pkg::HZ_W'($urandom_range(1100000, 1300000));
                default: hz = trt_pkg::HZ_W'($urandom_range(19, 1193180));
            endcase
            write_rate(hz);
            if (ticks_sent + quiet_items >= ITEM_TARGET - CALM_ITEMS)
                idling_on = 1'b0;
            burst = $urandom_range(60, 140);
            repeat (burst)
            begin
                tick_bit = ($urandom_range(0, 9) != 0);
                offer_item(tick_bit);
            end
        end

        // Drain and let the pipeline empty
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("covered %0d ticks and %0d ignored items over %0d rate writes",
                 ticks_sent, quiet_items, rates_written);
        $display("%0d result items compared, %0d mismatches", stamps_checked, mismatches);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== tick_rate_timekeeper_top.f =====
hdl/trt_pkg.sv
hdl/trt_in_if.sv
hdl/trt_out_if.sv
hdl/trt_div.sv
hdl/trt_mul.sv
hdl/tick_rate_timekeeper_top.sv
dv/trt_timebase_checker.sv
dv/tick_rate_timekeeper_top_test.sv
